[sv/nm3_pkg.sv]
// Shared constants, types and helper functions of the 3x3 neighbour mean block.
package nm3_pkg;

    // Frame geometry.
    localparam int MAX_SIDE = 32;
    localparam int MIN_SIDE = 2;
    localparam int SIDE_W   = 6;
    localparam int COL_W    = $clog2(MAX_SIDE);
    localparam int ROW_W    = COL_W;
    localparam int ADDR_W   = $clog2(3 * MAX_SIDE);
    localparam logic [SIDE_W-1:0] SIDE_RESET = SIDE_W'(8);

    // Pixel and arithmetic widths.
    localparam int PIX_W       = 8;
    localparam int SUM_W       = PIX_W + 3;
    localparam int CNT_W       = 4;
    localparam int MEAN_W      = 16;
    localparam int RECIP_W     = 21;
    localparam int RECIP_SHIFT = 14;
    localparam int PROD_W      = SUM_W + RECIP_W;

    // Neighbour sweep.
    localparam int NB_W = 3;
    localparam logic [NB_W-1:0] NB_LAST = NB_W'(7);

    // Offset codes for one neighbour in one direction.
    typedef enum logic [1:0] {
        OFF_NEG  = 2'd0,
        OFF_ZERO = 2'd1,
        OFF_POS  = 2'd2
    } off_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              wr_en;
        logic [1:0]        wr_m3;
        logic [COL_W-1:0]  wr_col;
        logic              nb_en;
        logic [NB_W-1:0]   nb_idx;
        logic              acc_clr;
        logic              mul_en;
        logic              load_en;
        logic [ROW_W-1:0]  tgt_row;
        logic [COL_W-1:0]  tgt_col;
        logic [1:0]        tgt_m3;
        logic [SIDE_W-1:0] side;
        logic              frame_end;
    } nm3_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } nm3_status_t;

    // Row offset of each of the eight neighbours.
    function automatic off_t nbr_row_off(input logic [NB_W-1:0] idx);
        off_t off;
        unique case (idx)
            3'd0, 3'd1, 3'd2: off = OFF_NEG;
            3'd3, 3'd4:       off = OFF_ZERO;
            default:          off = OFF_POS;
        endcase
        return off;
    endfunction

    // Column offset of each of the eight neighbours.
    function automatic off_t nbr_col_off(input logic [NB_W-1:0] idx);
        off_t off;
        unique case (idx)
            3'd0, 3'd3, 3'd5: off = OFF_NEG;
            3'd1, 3'd6:       off = OFF_ZERO;
            default:          off = OFF_POS;
        endcase
        return off;
    endfunction

    // Row index modulo three, stepped up by one.
    function automatic logic [1:0] m3_inc(input logic [1:0] m3);
        return (m3 == 2'd2) ? 2'd0 : m3 + 2'd1;
    endfunction

    // Row index modulo three, stepped down by one.
    function automatic logic [1:0] m3_dec(input logic [1:0] m3);
        return (m3 == 2'd0) ? 2'd2 : m3 - 2'd1;
    endfunction

    // Reciprocal of the neighbour count, scaled so that
    // (sum * recip) >> RECIP_SHIFT equals floor(256 * sum / count) exactly.
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
        logic [RECIP_W-1:0] r;
        case (cnt)
            4'd3:    r = RECIP_W'(1398102);
            4'd5:    r = RECIP_W'(838861);
            4'd8:    r = RECIP_W'(524288);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

[sv/nm3_datapath.sv]
// Datapath: line store, neighbour accumulator, reciprocal multiply and output register.
module nm3_datapath
    import nm3_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  nm3_cmd_t           cmd,
    output nm3_status_t        status,
    input  logic [PIX_W-1:0]   pixel,
    output logic [MEAN_W-1:0]  mean_q8,
    output logic               frame_end,
    output logic               result_valid,
    input  logic               result_stall
);

    logic [PIX_W-1:0]  line_mem [3*MAX_SIDE];
    logic [PIX_W-1:0]  rd_data_reg;
    logic              rd_pend_reg;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [PROD_W-1:0] prod_reg;
    logic [MEAN_W-1:0] mean_reg;
    logic              frame_end_reg;
    logic              result_valid_reg, result_valid_next;

    off_t              row_off, col_off;
    logic              in_frame;
    logic [1:0]        rd_m3;
    logic [COL_W-1:0]  rd_col;
    logic [ADDR_W-1:0] rd_addr, wr_addr;
    logic              rd_en;
    logic              out_free;
    logic              load;

    // Neighbour position and in-frame check for the current sweep step.
    always_comb
    begin
        row_off  = nbr_row_off(cmd.nb_idx);
        col_off  = nbr_col_off(cmd.nb_idx);
        in_frame = 1'b1;
        rd_m3    = cmd.tgt_m3;
        rd_col   = cmd.tgt_col;
        case (row_off)
            OFF_NEG:
            begin
                rd_m3 = m3_dec(cmd.tgt_m3);
                if (cmd.tgt_row == '0)
                    in_frame = 1'b0;
            end
            OFF_POS:
            begin
                rd_m3 = m3_inc(cmd.tgt_m3);
                if (SIDE_W'(cmd.tgt_row) == cmd.side - SIDE_W'(1))
                    in_frame = 1'b0;
            end
            default: ;
        endcase
        case (col_off)
            OFF_NEG:
            begin
                rd_col = cmd.tgt_col - COL_W'(1);
                if (cmd.tgt_col == '0)
                    in_frame = 1'b0;
            end
            OFF_POS:
            begin
                rd_col = cmd.tgt_col + COL_W'(1);
                if (SIDE_W'(cmd.tgt_col) == cmd.side - SIDE_W'(1))
                    in_frame = 1'b0;
            end
            default: ;
        endcase
    end

    assign rd_en   = cmd.nb_en & in_frame;
    assign rd_addr = ADDR_W'(rd_m3) * ADDR_W'(MAX_SIDE) + ADDR_W'(rd_col);
    assign wr_addr = ADDR_W'(cmd.wr_m3) * ADDR_W'(MAX_SIDE) + ADDR_W'(cmd.wr_col);

    // Line store: one write port for incoming pixels, one registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
            line_mem[wr_addr] <= pixel;
        if (rd_en)
            rd_data_reg <= line_mem[rd_addr];
    end

    // Read-pending flag is set in the cycle after each issued read.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rd_pend_reg <= 1'b0;
        else
            rd_pend_reg <= rd_en;
    end

    // Accumulate the sum and count of in-frame neighbours.
    always_comb
    begin
        sum_next = sum_reg;
        cnt_next = cnt_reg;
        if (cmd.acc_clr)
        begin
            sum_next = '0;
            cnt_next = '0;
        end
        else if (rd_pend_reg)
        begin
            sum_next = sum_reg + SUM_W'(rd_data_reg);
            cnt_next = cnt_reg + CNT_W'(1);
        end
    end

    // Accumulator and the reciprocal product.
    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
        cnt_reg <= cnt_next;
        if (cmd.mul_en)
            prod_reg <= PROD_W'(sum_reg) * PROD_W'(recip(cnt_reg));
    end

    // Output register: takes a new result when empty or when its transfer completes.
    assign out_free          = ~result_valid_reg | ~result_stall;
    assign load              = cmd.load_en & out_free;
    assign result_valid_next = load | (result_valid_reg & result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else
            result_valid_reg <= result_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            mean_reg      <= prod_reg[RECIP_SHIFT +: MEAN_W];
            frame_end_reg <= cmd.frame_end;
        end
    end

    assign status.out_free = out_free;
    assign mean_q8         = mean_reg;
    assign frame_end       = frame_end_reg;
    assign result_valid    = result_valid_reg;

endmodule

[sv/nm3_ctrl.sv]
// Controller: frame position, result schedule and the per-result sequencer.
module nm3_ctrl
    import nm3_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              frame_side_wr_en,
    input  logic [SIDE_W-1:0] frame_side_wr_data,
    input  logic              pixel_valid,
    output logic              pixel_stall,
    output nm3_cmd_t          cmd,
    input  nm3_status_t       status
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_NBR  = 5'b00010,
        ST_FIN  = 5'b00100,
        ST_MUL  = 5'b01000,
        ST_PUSH = 5'b10000
    } state_t;

    typedef enum logic [1:0] {
        PH_A     = 2'd0,
        PH_B     = 2'd1,
        PH_FLUSH = 2'd2
    } phase_t;

    state_t            state_reg, state_next;
    phase_t            phase_reg, phase_next;
    logic [SIDE_W-1:0] frame_side_reg, frame_side_next;
    logic [SIDE_W-1:0] side_reg, side_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [1:0]        rm3_reg, rm3_next;
    logic [ROW_W-1:0]  tgt_row_reg, tgt_row_next;
    logic [COL_W-1:0]  tgt_col_reg, tgt_col_next;
    logic [1:0]        tgt_m3_reg, tgt_m3_next;
    logic              flush_pend_reg, flush_pend_next;
    logic [NB_W-1:0]   nb_reg, nb_next;

    logic              accept;
    logic [SIDE_W-1:0] side_eff;
    logic [SIDE_W-1:0] side_cur;
    logic              last_col, last_row;
    logic              tgt_last_col;

    // Frame side clamped to the supported range.
    always_comb
    begin
        if (frame_side_reg < SIDE_W'(MIN_SIDE))
            side_eff = SIDE_W'(MIN_SIDE);
        else if (frame_side_reg > SIDE_W'(MAX_SIDE))
            side_eff = SIDE_W'(MAX_SIDE);
        else
            side_eff = frame_side_reg;
    end

    // The side is latched at the first pixel of each frame.
    assign side_cur     = (row_reg == '0 && col_reg == '0) ? side_eff : side_reg;
    assign last_col     = SIDE_W'(col_reg) == side_cur - SIDE_W'(1);
    assign last_row     = SIDE_W'(row_reg) == side_cur - SIDE_W'(1);
    assign tgt_last_col = SIDE_W'(tgt_col_reg) == side_reg - SIDE_W'(1);
    assign accept       = (state_reg == ST_IDLE) & pixel_valid;
    assign pixel_stall  = state_reg != ST_IDLE;

    assign frame_side_next = frame_side_wr_en ? frame_side_wr_data : frame_side_reg;

    // Sequencer and result schedule.
    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        side_next       = side_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        rm3_next        = rm3_reg;
        tgt_row_next    = tgt_row_reg;
        tgt_col_next    = tgt_col_reg;
        tgt_m3_next     = tgt_m3_reg;
        flush_pend_next = flush_pend_reg;
        nb_next         = nb_reg;

        cmd           = '0;
        cmd.wr_m3     = rm3_reg;
        cmd.wr_col    = col_reg;
        cmd.nb_idx    = nb_reg;
        cmd.tgt_row   = tgt_row_reg;
        cmd.tgt_col   = tgt_col_reg;
        cmd.tgt_m3    = tgt_m3_reg;
        cmd.side      = side_reg;
        cmd.frame_end = (SIDE_W'(tgt_row_reg) == side_reg - SIDE_W'(1)) & tgt_last_col;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.wr_en = 1'b1;
                    side_next = side_cur;
                    // The pixel above and to the left now has all its neighbours.
                    if (row_reg != '0 && col_reg != '0)
                    begin
                        tgt_row_next    = row_reg - ROW_W'(1);
                        tgt_col_next    = col_reg - COL_W'(1);
                        tgt_m3_next     = m3_dec(rm3_reg);
                        phase_next      = PH_A;
                        flush_pend_next = last_row & last_col;
                        nb_next         = '0;
                        state_next      = ST_NBR;
                    end
                    // Advance the raster position.
                    if (last_col)
                    begin
                        col_next = '0;
                        if (last_row)
                        begin
                            row_next = '0;
                            rm3_next = 2'd0;
                        end
                        else
                        begin
                            row_next = row_reg + ROW_W'(1);
                            rm3_next = m3_inc(rm3_reg);
                        end
                    end
                    else
                    begin
                        col_next = col_reg + COL_W'(1);
                    end
                end
            end
            ST_NBR:
            begin
                cmd.nb_en   = 1'b1;
                cmd.acc_clr = nb_reg == '0;
                if (nb_reg == NB_LAST)
                begin
                    nb_next    = '0;
                    state_next = ST_FIN;
                end
                else
                begin
                    nb_next = nb_reg + NB_W'(1);
                end
            end
            ST_FIN:
            begin
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul_en = 1'b1;
                state_next = ST_PUSH;
            end
            ST_PUSH:
            begin
                cmd.load_en = 1'b1;
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                    case (phase_reg)
                        PH_A:
                        begin
                            // Last column of a row also finishes the pixel above it.
                            if (SIDE_W'(tgt_col_reg) == side_reg - SIDE_W'(2))
                            begin
                                tgt_col_next = tgt_col_reg + COL_W'(1);
                                phase_next   = PH_B;
                                state_next   = ST_NBR;
                            end
                        end
                        PH_B:
                        begin
                            // The frame's last pixel flushes the whole last row.
                            if (flush_pend_reg)
                            begin
                                tgt_row_next = tgt_row_reg + ROW_W'(1);
                                tgt_m3_next  = m3_inc(tgt_m3_reg);
                                tgt_col_next = '0;
                                phase_next   = PH_FLUSH;
                                state_next   = ST_NBR;
                            end
                        end
                        PH_FLUSH:
                        begin
                            if (!tgt_last_col)
                            begin
                                tgt_col_next = tgt_col_reg + COL_W'(1);
                                state_next   = ST_NBR;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            phase_reg      <= PH_A;
            frame_side_reg <= SIDE_RESET;
            side_reg       <= SIDE_W'(MIN_SIDE);
            row_reg        <= '0;
            col_reg        <= '0;
            rm3_reg        <= 2'd0;
            tgt_row_reg    <= '0;
            tgt_col_reg    <= '0;
            tgt_m3_reg     <= 2'd0;
            flush_pend_reg <= 1'b0;
            nb_reg         <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            frame_side_reg <= frame_side_next;
            side_reg       <= side_next;
            row_reg        <= row_next;
            col_reg        <= col_next;
            rm3_reg        <= rm3_next;
            tgt_row_reg    <= tgt_row_next;
            tgt_col_reg    <= tgt_col_next;
            tgt_m3_reg     <= tgt_m3_next;
            flush_pend_reg <= flush_pend_next;
            nb_reg         <= nb_next;
        end
    end

endmodule

[sv/neighbour_mean_3x3.sv]
// Top level of the 3x3 neighbour mean block.
//
// Pixels of a square frame enter in raster order; for each pixel the block returns the
// mean of its in-frame neighbours (centre excluded) as unsigned Q8.8, truncated, in raster
// order, with frame_end set on the frame's last pixel. The side (2 to 32, clamped) is taken
// from frame_side at the first pixel of each frame; a write takes effect at the next frame.
// Results lag the input: a pixel's result is sent once the pixel below and to the right
// (the pixel below, in the last column) has arrived, and the frame's last pixel flushes
// the whole last row. One item is handled at a time. Each result a pixel releases takes
// eight reads through the line store's single read port, a step to collect the last read,
// the reciprocal multiply and the load of the output register, which waits out any output
// stall. So a pixel releases no result, one, two at the end of a row, or side + 2 for the
// frame's last pixel. The output register lets the next pixel transfer while a finished
// result still waits.
module neighbour_mean_3x3
    import nm3_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              frame_side_wr_en,
    input  logic [SIDE_W-1:0] frame_side_wr_data,
    input  logic [PIX_W-1:0]  pixel,
    input  logic              pixel_valid,
    output logic              pixel_stall,
    output logic [MEAN_W-1:0] mean_q8,
    output logic              frame_end,
    output logic              result_valid,
    input  logic              result_stall
);

    nm3_cmd_t    cmd;
    nm3_status_t status;

    // Sequencer.
    nm3_ctrl u_ctrl (
        .clk                (clk),
        .rst_n              (rst_n),
        .frame_side_wr_en   (frame_side_wr_en),
        .frame_side_wr_data (frame_side_wr_data),
        .pixel_valid        (pixel_valid),
        .pixel_stall        (pixel_stall),
        .cmd                (cmd),
        .status             (status)
    );

    // Line store and arithmetic.
    nm3_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .pixel        (pixel),
        .mean_q8      (mean_q8),
        .frame_end    (frame_end),
        .result_valid (result_valid),
        .result_stall (result_stall)
    );

endmodule
